[src/assert_macros.svh]
// Assertion macros shared by the key matrix debounce event RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in key matrix debounce block.");

// The consequent must hold in the cycle after the antecedent.
`define KMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed in key matrix debounce block.");

`endif

[src/kmd_pkg.sv]
// Shared constants and types for the key matrix debounce event block.
// Depends on nothing; used by the interfaces, the walker and the top level.
package kmd_pkg;

    localparam int FIELD_BITS = 54;
    localparam int INDEX_BITS = 6;

    localparam logic [FIELD_BITS-1:0] MOD_MASK_RESET = 54'h8;

    typedef struct packed {
        logic                  changed;
        logic                  now_bit;
        logic                  is_mod;
        logic                  last;
        logic                  empty;
        logic [INDEX_BITS-1:0] index;
    } walk_status_t;

endpackage

[src/kmd_channels.sv]
// Valid/ready channel interfaces for samples, events and configuration.
// Depends on kmd_pkg for the field widths.
interface kmd_sample_if;
    logic                            valid;
    logic                            ready;
    logic [kmd_pkg::FIELD_BITS-1:0]  raw_keys;

    modport source (output valid, output raw_keys, input ready);
    modport sink (input valid, input raw_keys, output ready);
endinterface

interface kmd_event_if;
    logic                            valid;
    logic                            ready;
    logic                            pressed;
    logic [kmd_pkg::INDEX_BITS-1:0]  key_index;
    logic                            modifier_held;
    logic [kmd_pkg::INDEX_BITS-1:0]  modifier_key;
    logic                            last_in_run;

    modport source (output valid, output pressed, output key_index, output modifier_held,
                    output modifier_key, output last_in_run, input ready);
    modport sink (input valid, input pressed, input key_index, input modifier_held,
                  input modifier_key, input last_in_run, output ready);
endinterface

interface kmd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kmd_pkg::FIELD_BITS-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/key_matrix_debounce_events_unit.sv]
// Each accepted sample of the key matrix is debounced against the previous sample, and
// every key whose debounced state changed is reported as one event, lowest index first,
// with the last event of a sample marked. After a sample is accepted, the walker steps
// through each key position up to the highest changed key, at most ROWS*COLS (capped
// at 54), and then returns to idle. The walker shifts the change vector one bit a
// cycle, but holds while a changed bit waits for the event output to take it.
// The sample channel is not ready during the walk; configuration is always ready.
// Depends on kmd_pkg, the channel interfaces, kmd_walker and assert_macros.svh.
`include "assert_macros.svh"

module key_matrix_debounce_events_unit
#(
    parameter int ROWS = 9,
    parameter int COLS = 6
)
(
    input  logic           clk,
    input  logic           rst_n,
    kmd_sample_if.sink     sample,
    kmd_cfg_if.sink        cfg,
    kmd_event_if.source    evt
);

    localparam int KEY_COUNT = (ROWS * COLS > kmd_pkg::FIELD_BITS) ?
                               kmd_pkg::FIELD_BITS : ROWS * COLS;
    localparam logic [kmd_pkg::FIELD_BITS-1:0] KEY_MASK =
        (KEY_COUNT >= kmd_pkg::FIELD_BITS) ? {kmd_pkg::FIELD_BITS{1'b1}} :
        ((kmd_pkg::FIELD_BITS'(1) << KEY_COUNT) - kmd_pkg::FIELD_BITS'(1));

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [kmd_pkg::FIELD_BITS-1:0]  mask_reg;
    logic [kmd_pkg::FIELD_BITS-1:0]  prev_reg;
    logic [kmd_pkg::FIELD_BITS-1:0]  deb_reg;
    logic                            held_valid_reg;
    logic                            held_valid_next;
    logic [kmd_pkg::INDEX_BITS-1:0]  held_idx_reg;
    logic [kmd_pkg::INDEX_BITS-1:0]  held_idx_next;

    logic                            ovalid_reg;
    logic                            ovalid_next;
    logic                            opressed_reg;
    logic [kmd_pkg::INDEX_BITS-1:0]  okey_reg;
    logic                            oheld_reg;
    logic [kmd_pkg::INDEX_BITS-1:0]  omod_reg;
    logic                            olast_reg;

    logic [kmd_pkg::FIELD_BITS-1:0]  sample_masked;
    logic [kmd_pkg::FIELD_BITS-1:0]  now_keys;
    logic [kmd_pkg::FIELD_BITS-1:0]  changed;
    logic                            accept;
    logic                            walking;
    logic                            can_load;
    logic                            emit;
    logic                            advance;
    kmd_pkg::walk_status_t           stat;

    assign sample_masked = sample.raw_keys & KEY_MASK;
    assign now_keys      = sample_masked & prev_reg;
    assign changed       = (now_keys ^ deb_reg) & KEY_MASK;
    assign accept        = sample.valid & sample.ready;
    assign walking       = (state_reg == ST_WALK);
    assign can_load      = ~ovalid_reg | evt.ready;
    assign emit          = walking & ~stat.empty & stat.changed & can_load;
    assign advance       = walking & ~stat.empty & (~stat.changed | can_load);

    assign sample.ready  = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;

    kmd_walker u_walker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .advance  (advance),
        .changed  (changed),
        .now_keys (now_keys),
        .mod_mask (mask_reg),
        .status   (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        if (emit && stat.is_mod)
        begin
            held_valid_next = stat.now_bit;
            held_idx_next   = stat.now_bit ? stat.index : '0;
        end
    end

    assign ovalid_next = emit | (ovalid_reg & ~evt.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mask_reg       <= kmd_pkg::MOD_MASK_RESET;
            prev_reg       <= '0;
            deb_reg        <= '0;
            held_valid_reg <= 1'b0;
            held_idx_reg   <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            held_idx_reg   <= held_idx_next;
            ovalid_reg     <= ovalid_next;
            if (cfg.valid && cfg.ready)
            begin
                mask_reg <= cfg.data;
            end
            if (accept)
            begin
                prev_reg <= sample_masked;
                deb_reg  <= now_keys;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            opressed_reg <= stat.now_bit;
            okey_reg     <= stat.index;
            oheld_reg    <= ~stat.is_mod & held_valid_reg;
            omod_reg     <= (~stat.is_mod & held_valid_reg) ? held_idx_reg : '0;
            olast_reg    <= stat.last;
        end
    end

    assign evt.valid         = ovalid_reg;
    assign evt.pressed       = opressed_reg;
    assign evt.key_index     = okey_reg;
    assign evt.modifier_held = oheld_reg;
    assign evt.modifier_key  = omod_reg;
    assign evt.last_in_run   = olast_reg;

    `KMD_ASSERT_NEXT(a_accept_starts_walk, clk, rst_n, accept, state_reg == ST_WALK)
    `KMD_ASSERT_NEXT(a_emit_loads_output, clk, rst_n, emit, ovalid_reg && okey_reg == $past(stat.index))
    `KMD_ASSERT_NEXT(a_mod_press_held, clk, rst_n, emit && stat.is_mod && stat.now_bit, held_valid_reg && held_idx_reg == $past(stat.index))
    `KMD_ASSERT_SAME(a_walk_blocks_sample, clk, rst_n, walking, !accept)

endmodule

[src/kmd_walker.sv]
// Shift walker that steps through the changed-key vector one key per cycle while advance is high.
// Depends on kmd_pkg for widths and the status struct.
module kmd_walker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            advance,
    input  logic [kmd_pkg::FIELD_BITS-1:0]  changed,
    input  logic [kmd_pkg::FIELD_BITS-1:0]  now_keys,
    input  logic [kmd_pkg::FIELD_BITS-1:0]  mod_mask,
    output kmd_pkg::walk_status_t           status
);

    logic [kmd_pkg::FIELD_BITS-1:0] chg_reg;
    logic [kmd_pkg::FIELD_BITS-1:0] chg_next;
    logic [kmd_pkg::FIELD_BITS-1:0] now_reg;
    logic [kmd_pkg::FIELD_BITS-1:0] now_next;
    logic [kmd_pkg::FIELD_BITS-1:0] mod_reg;
    logic [kmd_pkg::FIELD_BITS-1:0] mod_next;
    logic [kmd_pkg::INDEX_BITS-1:0] idx_reg;
    logic [kmd_pkg::INDEX_BITS-1:0] idx_next;

    always_comb
    begin
        chg_next = chg_reg;
        now_next = now_reg;
        mod_next = mod_reg;
        idx_next = idx_reg;
        if (load)
        begin
            chg_next = changed;
            now_next = now_keys;
            mod_next = mod_mask;
            idx_next = '0;
        end
        else if (advance)
        begin
            chg_next = chg_reg >> 1;
            now_next = now_reg >> 1;
            mod_next = mod_reg >> 1;
            idx_next = idx_reg + kmd_pkg::INDEX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chg_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            chg_reg <= chg_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        mod_reg <= mod_next;
    end

    always_comb
    begin
        status.changed = chg_reg[0];
        status.now_bit = now_reg[0];
        status.is_mod  = mod_reg[0];
        status.last    = ~|chg_reg[kmd_pkg::FIELD_BITS-1:1];
        status.empty   = ~|chg_reg;
        status.index   = idx_reg;
    end

endmodule
